// File: rtl/n_queens_solution_counter_top_macros.svh
// ----------------------------------------------------------------------------
// n-queens solution counter assertion macros
// shared concurrent assertion wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef N_QUEENS_SOLUTION_COUNTER_TOP_MACROS_SVH
`define N_QUEENS_SOLUTION_COUNTER_TOP_MACROS_SVH

`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define NQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nq assertion failed");
// antecedent implies consequent in the next cycle
`define NQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nq assertion failed");
`else
`define NQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define NQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/nq_pkg.sv
// ----------------------------------------------------------------------------
// nq_pkg
// shared types and constants of the n-queens solution counter
// ----------------------------------------------------------------------------
package nq_pkg;

    localparam int CFG_W       = 5;
    localparam int COUNT_W     = 24;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

    localparam logic [CFG_W-1:0] BOARD_SIZE_RESET = 5'd8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INIT,
        ST_RUN,
        ST_POP
    } t_nq_state;

    // status from the search engine to the stream wrapper
    typedef struct packed {
        logic               busy;
        logic               done;
        logic [COUNT_W-1:0] count;
    } t_srch_stat;

endpackage

// File: rtl/nq_stack.sv
// ----------------------------------------------------------------------------
// nq_stack
// per-row backtrack stack, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module nq_stack #(
    parameter int MAX_SIZE = 16,
    localparam int AW = $clog2(MAX_SIZE),
    localparam int EW = 4 * MAX_SIZE
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [EW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [EW-1:0] o_rdata
);

    logic [EW-1:0] mem [MAX_SIZE];
    logic [EW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/nq_search.sv
// ----------------------------------------------------------------------------
// nq_search
// depth-first backtracking engine, row state pushed to and popped from the stack
// ----------------------------------------------------------------------------
`include "n_queens_solution_counter_top_macros.svh"

module nq_search #(
    parameter int MAX_SIZE = 16,
    localparam int AW = $clog2(MAX_SIZE),
    localparam int SW = $clog2(MAX_SIZE + 1),
    localparam int MW = MAX_SIZE,
    localparam int EW = 4 * MAX_SIZE
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [SW-1:0]      i_size,
    output nq_pkg::t_srch_stat o_stat,
    output logic               o_stk_we,
    output logic [AW-1:0]      o_stk_waddr,
    output logic [EW-1:0]      o_stk_wdata,
    output logic [AW-1:0]      o_stk_raddr,
    input  logic [EW-1:0]      i_stk_rdata
);

    import nq_pkg::*;

    t_nq_state          r_state, n_state;
    logic [SW-1:0]      r_size, n_size;
    logic [AW-1:0]      r_row, n_row;
    logic [MW-1:0]      r_cols, n_cols;
    logic [MW-1:0]      r_left, n_left;
    logic [MW-1:0]      r_right, n_right;
    logic [MW-1:0]      r_open, n_open;
    logic               r_mid, n_mid;
    logic [COUNT_W-1:0] r_total, n_total;
    logic               r_done, n_done;

    logic [MW-1:0] full_m, half_m, mid_m;
    logic [MW-1:0] lowbit, open_rest;
    logic [MW-1:0] cols_nx, left_nx, right_nx;
    logic [SW-1:0] last_row;

    // column masks for the active board size
    always_comb begin
        for (int i = 0; i < MW; i++) begin
            full_m[i] = (SW'(i) < r_size);
            half_m[i] = (SW'(i) < (r_size >> 1));
            mid_m[i]  = (SW'(i) == (r_size >> 1));
        end
    end

    assign lowbit    = r_open & (~r_open + MW'(1));
    assign open_rest = r_open & ~lowbit;
    assign cols_nx   = r_cols | lowbit;
    assign left_nx   = ((r_left | lowbit) << 1) & full_m;
    assign right_nx  = (r_right | lowbit) >> 1;
    assign last_row  = r_size - SW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_row   <= '0;
            r_mid   <= 1'b0;
            r_total <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_mid   <= n_mid;
            r_total <= n_total;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_size  <= n_size;
        r_cols  <= n_cols;
        r_left  <= n_left;
        r_right <= n_right;
        r_open  <= n_open;
    end

    always_comb begin
        n_state     = r_state;
        n_size      = r_size;
        n_row       = r_row;
        n_cols      = r_cols;
        n_left      = r_left;
        n_right     = r_right;
        n_open      = r_open;
        n_mid       = r_mid;
        n_total     = r_total;
        n_done      = 1'b0;
        o_stk_we    = 1'b0;
        o_stk_waddr = r_row;
        o_stk_wdata = {open_rest, r_cols, r_left, r_right};
        o_stk_raddr = r_row - AW'(1);
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_INIT;
                    n_size  = i_size;
                    n_row   = '0;
                    n_cols  = '0;
                    n_left  = '0;
                    n_right = '0;
                    n_mid   = 1'b0;
                    n_total = '0;
                end
            end
            ST_INIT: begin
                // first row walks the lower half only, mirrored later
                n_open  = half_m;
                n_state = ST_RUN;
            end
            ST_RUN: begin
                if (r_open == '0) begin
                    if (r_row == '0) begin
                        if (!r_mid && r_size[0]) begin
                            n_total = r_total << 1;
                            n_open  = mid_m;
                            n_mid   = 1'b1;
                        end else begin
                            if (!r_mid) begin
                                n_total = r_total << 1;
                            end
                            if (r_size == '0) begin
                                n_total = COUNT_W'(1);
                            end
                            n_state = ST_IDLE;
                            n_done  = 1'b1;
                        end
                    end else begin
                        n_state = ST_POP;
                    end
                end else if (SW'(r_row) == last_row) begin
                    n_total = r_total + COUNT_W'(1);
                    n_open  = open_rest;
                end else begin
                    o_stk_we = 1'b1;
                    n_cols   = cols_nx;
                    n_left   = left_nx;
                    n_right  = right_nx;
                    n_open   = ~(cols_nx | left_nx | right_nx) & full_m;
                    n_row    = r_row + AW'(1);
                end
            end
            ST_POP: begin
                {n_open, n_cols, n_left, n_right} = i_stk_rdata;
                n_row   = r_row - AW'(1);
                n_state = ST_RUN;
            end
        endcase
    end

    assign o_stat.busy  = (r_state != ST_IDLE);
    assign o_stat.done  = r_done;
    assign o_stat.count = r_total;

    `NQ_ASSERT_IMP(a_pop_above_root, i_clk, i_rst_n, r_state == ST_POP, r_row != '0)
    `NQ_ASSERT_IMP(a_push_below_last, i_clk, i_rst_n, o_stk_we, SW'(r_row) < last_row)
    `NQ_ASSERT_NXT(a_done_pulse, i_clk, i_rst_n, r_done, !r_done)
    `NQ_ASSERT_IMP(a_open_on_board, i_clk, i_rst_n, r_state == ST_RUN, (r_open & ~full_m) == '0)

endmodule

// File: rtl/n_queens_solution_counter_top.sv
// ----------------------------------------------------------------------------
// n_queens_solution_counter_top
// stream wrapper around the n-queens backtracking search engine
// ----------------------------------------------------------------------------
// An item with start_req set counts all placements of board_size
// non-attacking queens and returns one item holding the total; an item with
// start_req clear is taken and dropped. The search walks the tree one step a
// cycle, depth first: each queen placed pushes its row state to the stack,
// each exhausted row pops the parent state back through a registered read.
// The first row only walks the lower half of the columns and the partial
// count is doubled, plus the middle column on odd sizes. board_size above
// MAX_SIZE is treated as MAX_SIZE, size zero returns one. Input is taken
// only while the engine is idle and the output register is empty.
// ----------------------------------------------------------------------------
`include "n_queens_solution_counter_top_macros.svh"

module n_queens_solution_counter_top #(
    parameter int MAX_SIZE = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write: board_size
    input  logic                           i_cfg_we,
    input  logic [nq_pkg::CFG_W-1:0]       i_cfg_wdata,
    // request stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [nq_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // [0] start_req, rest zero
    // result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [nq_pkg::OUT_TDATA_W-1:0] m_axis_tdata    // [23:0] solution_count
);

    import nq_pkg::*;

    localparam int AW = $clog2(MAX_SIZE);
    localparam int SW = $clog2(MAX_SIZE + 1);
    localparam int EW = 4 * MAX_SIZE;

    logic [CFG_W-1:0]   r_board;
    logic               r_out_valid, n_out_valid;
    logic [COUNT_W-1:0] r_out_count, n_out_count;

    logic               start;
    logic [SW-1:0]      size_sat;
    t_srch_stat         stat;

    logic               stk_we;
    logic [AW-1:0]      stk_waddr;
    logic [EW-1:0]      stk_wdata;
    logic [AW-1:0]      stk_raddr;
    logic [EW-1:0]      stk_rdata;

    // board size register; the user must write it only while idle, the block itself does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_board <= BOARD_SIZE_RESET;
        end else if (i_cfg_we) begin
            r_board <= i_cfg_wdata;
        end
    end

    // clamp oversize boards to what the stack can hold
    assign size_sat = (r_board > CFG_W'(MAX_SIZE)) ? SW'(MAX_SIZE) : SW'(r_board);

    // one item at a time: engine idle, no finished result pending
    assign s_axis_tready = !stat.busy && !stat.done && !r_out_valid;
    assign start         = s_axis_tvalid && s_axis_tready && s_axis_tdata[0];

    nq_search #(
        .MAX_SIZE (MAX_SIZE)
    ) u_search (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_size      (size_sat),
        .o_stat      (stat),
        .o_stk_we    (stk_we),
        .o_stk_waddr (stk_waddr),
        .o_stk_wdata (stk_wdata),
        .o_stk_raddr (stk_raddr),
        .i_stk_rdata (stk_rdata)
    );

    nq_stack #(
        .MAX_SIZE (MAX_SIZE)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    // output register holds the total until the item is taken
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_count = r_out_count;
        if (stat.done) begin
            n_out_valid = 1'b1;
            n_out_count = stat.count;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_count <= n_out_count;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_count;

    `NQ_ASSERT_IMP(a_no_take_while_pending, i_clk, i_rst_n, r_out_valid, !s_axis_tready)
    `NQ_ASSERT_IMP(a_done_into_empty, i_clk, i_rst_n, stat.done, !r_out_valid)
    `NQ_ASSERT_IMP(a_no_take_while_busy, i_clk, i_rst_n, stat.busy, !s_axis_tready)

endmodule
